[design/ctb_pkg.sv]
// ----------------------------------------------------------------------------
// ctb_pkg: shared types and constants of the capped step trace buffer
// Store geometry, field widths, operation and mode codes, and the structs
// that pass between the control core, the point memory and the result queue.
// ----------------------------------------------------------------------------
package ctb_pkg;

  // Store depth: a power of two, so slot arithmetic wraps by truncation.
  localparam int DEPTH      = 1024;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = ADDR_W + 1;

  localparam int OP_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CAP_W      = 11;
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 32;
  localparam int IDX_W      = 10;
  localparam int SCNT_W     = 11;
  localparam int WR_W       = 2;
  localparam int PT_W       = TIME_W + VAL_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_PLAIN  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHANGE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  typedef struct packed {
    logic [SCNT_W-1:0]       stored_count;
    logic [WR_W-1:0]         points_written;
    logic                    end_moved;
    logic                    read_hit;
    logic [TIME_W-1:0]       read_time;
    logic signed [VAL_W-1:0] read_value;
  } res_t;

  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PT_W-1:0]   wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[design/ctb_ram.sv]
// ----------------------------------------------------------------------------
// ctb_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ctb_ram #(
  parameter int DATA_W = 64,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  localparam int WORDS = 1 << ADDR_W;

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/ctb_out_fifo.sv]
// ----------------------------------------------------------------------------
// ctb_out_fifo: two-entry result queue
// Ring of two entries; decouples result delivery from intake.
// ----------------------------------------------------------------------------
module ctb_out_fifo (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctb_pkg::push_t                push,
  output logic                          full,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ctb_pkg::SCNT_W-1:0]    out_stored_count,
  output logic [ctb_pkg::WR_W-1:0]      out_points_written,
  output logic                          out_end_moved,
  output logic                          out_read_hit,
  output logic [ctb_pkg::TIME_W-1:0]    out_read_time,
  output logic signed [ctb_pkg::VAL_W-1:0] out_read_value
);
  import ctb_pkg::*;

  res_t       ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pop;
  res_t       head;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign head      = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push.valid, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      ent_r[wr_ptr_r] <= push.res;
    end
  end

  assign out_stored_count   = head.stored_count;
  assign out_points_written = head.points_written;
  assign out_end_moved      = head.end_moved;
  assign out_read_hit       = head.read_hit;
  assign out_read_time      = head.read_time;
  assign out_read_value     = head.read_value;

endmodule

[design/ctb_core.sv]
// ----------------------------------------------------------------------------
// ctb_core: trace buffer control
// Holds ring pointers, last values and configuration; decides each request's
// action, drives the point memory and pushes one result per request.
// ----------------------------------------------------------------------------
module ctb_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ctb_pkg::OP_W-1:0]          in_op,
  input  logic [ctb_pkg::TIME_W-1:0]        in_timestamp,
  input  logic signed [ctb_pkg::VAL_W-1:0]  in_sample_value,
  input  logic [ctb_pkg::IDX_W-1:0]         in_read_index,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctb_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              fifo_full,
  output ctb_pkg::push_t                    push,
  output ctb_pkg::mem_req_t                 mem_req,
  input  logic [ctb_pkg::PT_W-1:0]          mem_rdata
);
  import ctb_pkg::*;

  typedef enum logic {S_IDLE, S_SECOND} state_t;

  state_t             st_r, st_nxt;
  logic [ADDR_W-1:0]  oldest_r, oldest_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [VAL_W-1:0]   last_value_r, last_value_nxt;
  logic               last_valid_r, last_valid_nxt;
  logic [VAL_W-1:0]   prior_value_r, prior_value_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic               is_read_r, is_read_nxt;
  logic               hit_r, hit_nxt;
  logic [TIME_W-1:0]  t_r;
  logic [VAL_W-1:0]   v_r;

  logic               accept;
  logic [CNT_W-1:0]   eff_cap;
  logic [CNT_W-1:0]   ap_n;
  logic [ADDR_W-1:0]  ap_slot;
  logic [ADDR_W-1:0]  end_slot;
  logic               ap_en;
  logic [TIME_W-1:0]  ap_time;
  logic [VAL_W-1:0]   ap_value;
  logic               do_move;
  logic               go_second;
  logic [WR_W-1:0]    written;
  logic               hit_now;

  assign in_ready  = (st_r == S_IDLE) && !fifo_full;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // Capacity zero or beyond the store falls back to the full depth.
  assign eff_cap  = (cap_r == '0 || cap_r > CAP_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(cap_r);
  assign ap_n     = count_r + CNT_W'(1);
  assign ap_slot  = oldest_r + count_r[ADDR_W-1:0];
  assign end_slot = ap_slot - ADDR_W'(1);
  assign hit_now  = CNT_W'(in_read_index) < count_r;

  always_comb begin
    st_nxt          = st_r;
    oldest_nxt      = oldest_r;
    count_nxt       = count_r;
    last_value_nxt  = last_value_r;
    last_valid_nxt  = last_valid_r;
    prior_value_nxt = prior_value_r;
    mode_nxt        = mode_r;
    cap_nxt         = cap_r;
    is_read_nxt     = is_read_r;
    hit_nxt         = hit_r;
    ap_en           = 1'b0;
    ap_time         = in_timestamp;
    ap_value        = in_sample_value;
    do_move         = 1'b0;
    go_second       = 1'b0;
    written         = '0;
    push            = '0;

    if (cfg_valid) begin
      case (cfg_index)
        CFG_RECORD_MODE: mode_nxt = cfg_data[MODE_W-1:0];
        CFG_CAPACITY:    cap_nxt  = cfg_data[CAP_W-1:0];
        default:         ;
      endcase
    end

    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_RECORD: begin
              case (mode_r)
                MODE_PLAIN: begin
                  ap_en   = 1'b1;
                  written = WR_W'(1);
                end
                MODE_CHANGE: begin
                  if (!(last_valid_r && last_value_r == in_sample_value)) begin
                    ap_en   = 1'b1;
                    written = WR_W'(1);
                  end
                end
                MODE_STEP: begin
                  if (!last_valid_r || count_r == '0) begin
                    ap_en   = 1'b1;
                    written = WR_W'(1);
                  end else if (last_value_r != in_sample_value) begin
                    // Corner point now, new point in state S_SECOND.
                    ap_en     = 1'b1;
                    ap_value  = last_value_r;
                    go_second = 1'b1;
                  end else if (count_r >= CNT_W'(2) && prior_value_r == in_sample_value) begin
                    do_move = 1'b1;
                  end else begin
                    ap_en   = 1'b1;
                    written = WR_W'(1);
                  end
                end
                default: ;
              endcase
            end
            OP_CLEAR: begin
              count_nxt       = '0;
              oldest_nxt      = '0;
              last_valid_nxt  = 1'b0;
              last_value_nxt  = '0;
              prior_value_nxt = '0;
            end
            OP_READ: begin
              go_second = 1'b1;
            end
            default: ;
          endcase
          is_read_nxt = (in_op == OP_READ);
          hit_nxt     = hit_now;
          if (go_second) begin
            st_nxt = S_SECOND;
          end
        end
      end
      S_SECOND: begin
        st_nxt = S_IDLE;
        if (!is_read_r) begin
          ap_en    = 1'b1;
          ap_time  = t_r;
          ap_value = v_r;
          written  = WR_W'(2);
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    if (ap_en) begin
      if (count_r != '0) begin
        prior_value_nxt = last_value_r;
      end
      last_value_nxt = ap_value;
      last_valid_nxt = 1'b1;
      // Drop the oldest points that no longer fit.
      if (ap_n > eff_cap) begin
        count_nxt  = eff_cap;
        oldest_nxt = oldest_r + ADDR_W'(ap_n - eff_cap);
      end else begin
        count_nxt = ap_n;
      end
    end

    if ((st_r == S_IDLE && accept && !go_second) || st_r == S_SECOND) begin
      push.valid              = 1'b1;
      push.res.stored_count   = SCNT_W'(count_nxt);
      push.res.points_written = written;
      push.res.end_moved      = do_move;
      if (st_r == S_SECOND && is_read_r && hit_r) begin
        push.res.read_hit   = 1'b1;
        push.res.read_time  = mem_rdata[PT_W-1 -: TIME_W];
        push.res.read_value = mem_rdata[VAL_W-1:0];
      end
    end
  end

  always_comb begin
    mem_req.we    = ap_en || do_move;
    mem_req.waddr = do_move ? end_slot : ap_slot;
    mem_req.wdata = {ap_time, ap_value};
    mem_req.raddr = oldest_r + ADDR_W'(in_read_index);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r          <= S_IDLE;
      oldest_r      <= '0;
      count_r       <= '0;
      last_value_r  <= '0;
      last_valid_r  <= 1'b0;
      prior_value_r <= '0;
      mode_r        <= MODE_PLAIN;
      cap_r         <= CAP_RESET;
      is_read_r     <= 1'b0;
      hit_r         <= 1'b0;
    end else begin
      st_r          <= st_nxt;
      oldest_r      <= oldest_nxt;
      count_r       <= count_nxt;
      last_value_r  <= last_value_nxt;
      last_valid_r  <= last_valid_nxt;
      prior_value_r <= prior_value_nxt;
      mode_r        <= mode_nxt;
      cap_r         <= cap_nxt;
      is_read_r     <= is_read_nxt;
      hit_r         <= hit_nxt;
    end
  end

  // Hold the sample for the second point of a step change.
  always_ff @(posedge clk) begin
    if (accept) begin
      t_r <= in_timestamp;
      v_r <= in_sample_value;
    end
  end

endmodule

[design/capped_step_trace_buffer.sv]
// ----------------------------------------------------------------------------
// capped_step_trace_buffer: capped circular trace buffer with step recording
// Record, clear and no-op requests are answered from the idle state; a read
//   (registered memory port) and a step change (two memory writes) also
//   pass through S_SECOND, where no new request is taken.
// Throughput: one request per cycle while idle and the result queue has room.
// Reset: synchronous, active low; clears pointers, count, last values and
//   configuration; point memory contents stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
module capped_step_trace_buffer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ctb_pkg::OP_W-1:0]          in_op,
  input  logic [ctb_pkg::TIME_W-1:0]        in_timestamp,
  input  logic signed [ctb_pkg::VAL_W-1:0]  in_sample_value,
  input  logic [ctb_pkg::IDX_W-1:0]         in_read_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ctb_pkg::SCNT_W-1:0]        out_stored_count,
  output logic [ctb_pkg::WR_W-1:0]          out_points_written,
  output logic                              out_end_moved,
  output logic                              out_read_hit,
  output logic [ctb_pkg::TIME_W-1:0]        out_read_time,
  output logic signed [ctb_pkg::VAL_W-1:0]  out_read_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ctb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ctb_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ctb_pkg::*;

  push_t           push;
  mem_req_t        mem_req;
  logic [PT_W-1:0] mem_rdata;
  logic            fifo_full;

  ctb_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_timestamp    (in_timestamp),
    .in_sample_value (in_sample_value),
    .in_read_index   (in_read_index),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fifo_full       (fifo_full),
    .push            (push),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  ctb_ram #(
    .DATA_W (PT_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  ctb_out_fifo u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .push               (push),
    .full               (fifo_full),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_stored_count   (out_stored_count),
    .out_points_written (out_points_written),
    .out_end_moved      (out_end_moved),
    .out_read_hit       (out_read_hit),
    .out_read_time      (out_read_time),
    .out_read_value     (out_read_value)
  );

endmodule

[verif/tb_capped_step_trace_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capped_step_trace_buffer: self-checking bench for the trace buffer
// Drives record, clear, read and no-op requests in all record modes and a
// range of capacities, predicts every result from a software copy of the
// point store, and compares the results field by field in order.
// ----------------------------------------------------------------------------
module tb_capped_step_trace_buffer;
  import ctb_pkg::*;

  localparam logic [OP_W-1:0]      OP_NOP      = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_OFF    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3  = 2'd3;
  localparam int                   STALL_LIMIT = 2000;

  class trace_checker;
    logic [TIME_W-1:0] time_store [DEPTH];
    logic [VAL_W-1:0]  value_store [DEPTH];
    logic [ADDR_W-1:0] oldest_slot;
    logic [CNT_W-1:0]  point_count;
    logic [VAL_W-1:0]  last_value;
    logic [VAL_W-1:0]  prior_value;
    bit                last_valid;
    logic [MODE_W-1:0] record_mode;
    logic [CAP_W-1:0]  capacity;
    res_t              predicted_results [$];
    int                error_count;
    int                request_count;
    int                result_count;
    int                hit_count;
    int                step_count;
    int                move_count;
    int                peak_count;

    function new();
      oldest_slot = '0;
      point_count = '0;
      last_value  = '0;
      prior_value = '0;
      last_valid  = 1'b0;
      record_mode = MODE_PLAIN;
      capacity    = CAP_RESET;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      if (index == CFG_RECORD_MODE)
        record_mode = data[MODE_W-1:0];
      else if (index == CFG_CAPACITY)
        capacity = data;
    endfunction

    function void store_point(logic [TIME_W-1:0] t, logic [VAL_W-1:0] v);
      int unsigned       cap;
      logic [ADDR_W-1:0] slot;
      cap = (capacity == 0 || capacity > DEPTH) ? DEPTH : capacity;
      slot = oldest_slot + point_count[ADDR_W-1:0];
      if (point_count != 0)
        prior_value = last_value;
      time_store[slot]  = t;
      value_store[slot] = v;
      if (point_count < DEPTH)
        point_count++;
      else
        oldest_slot++;
      // drop the oldest points beyond the capacity
      if (point_count > cap) begin
        oldest_slot = oldest_slot + ADDR_W'(point_count - cap);
        point_count = CNT_W'(cap);
      end
      last_value = v;
      last_valid = 1'b1;
    endfunction

    function void predict_response(logic [OP_W-1:0] op, logic [TIME_W-1:0] t,
                                   logic [VAL_W-1:0] v, logic [IDX_W-1:0] idx);
      res_t              r;
      logic [ADDR_W-1:0] slot;
      r = '0;
      request_count++;
      case (op)
        OP_RECORD: begin
          case (record_mode)
            MODE_PLAIN: begin
              store_point(t, v);
              r.points_written = 2'd1;
            end
            MODE_CHANGE: begin
              if (!(last_valid && last_value == v)) begin
                store_point(t, v);
                r.points_written = 2'd1;
              end
            end
            MODE_STEP: begin
              if (!last_valid || point_count == 0) begin
                store_point(t, v);
                r.points_written = 2'd1;
              end else if (last_value != v) begin
                // close the old level with a corner at the new time
                store_point(t, last_value);
                store_point(t, v);
                r.points_written = 2'd2;
                step_count++;
              end else if (point_count >= 2 && prior_value == v) begin
                slot = oldest_slot + point_count[ADDR_W-1:0] - 1'b1;
                time_store[slot] = t;
                r.end_moved = 1'b1;
                move_count++;
              end else begin
                store_point(t, v);
                r.points_written = 2'd1;
              end
            end
            default: ;
          endcase
        end
        OP_CLEAR: begin
          point_count = '0;
          oldest_slot = '0;
          last_valid  = 1'b0;
          last_value  = '0;
          prior_value = '0;
        end
        OP_READ: begin
          if (idx < point_count) begin
            slot = oldest_slot + idx;
            r.read_hit   = 1'b1;
            r.read_time  = time_store[slot];
            r.read_value = value_store[slot];
            hit_count++;
          end
        end
        default: ;
      endcase
      r.stored_count = point_count;
      if (point_count > peak_count)
        peak_count = point_count;
      predicted_results.insert(predicted_results.size(), r);
    endfunction

    task report_mismatch(string msg);
      error_count++;
      if (error_count <= 100)
        $display("%0t ERROR result %0d: %s", $time, result_count, msg);
    endtask

    task check_response(res_t got);
      res_t want;
      result_count++;
      if (predicted_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, count %0d", got.stored_count));
        return;
      end
      want = predicted_results.pop_front();
      if (got.stored_count !== want.stored_count)
        report_mismatch($sformatf("stored_count %0d, want %0d",
                                  got.stored_count, want.stored_count));
      if (got.points_written !== want.points_written)
        report_mismatch($sformatf("points_written %0d, want %0d",
                                  got.points_written, want.points_written));
      if (got.end_moved !== want.end_moved)
        report_mismatch($sformatf("end_moved %0b, want %0b", got.end_moved, want.end_moved));
      if (got.read_hit !== want.read_hit)
        report_mismatch($sformatf("read_hit %0b, want %0b", got.read_hit, want.read_hit));
      if (got.read_time !== want.read_time)
        report_mismatch($sformatf("read_time %h, want %h", got.read_time, want.read_time));
      if (got.read_value !== want.read_value)
        report_mismatch($sformatf("read_value %h, want %h", got.read_value, want.read_value));
    endtask

    function int pending();
      return predicted_results.size();
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_op;
  logic [TIME_W-1:0]       in_timestamp;
  logic signed [VAL_W-1:0] in_sample_value;
  logic [IDX_W-1:0]        in_read_index;
  logic                    out_valid;
  logic                    out_ready;
  logic [SCNT_W-1:0]       out_stored_count;
  logic [WR_W-1:0]         out_points_written;
  logic                    out_end_moved;
  logic                    out_read_hit;
  logic [TIME_W-1:0]       out_read_time;
  logic signed [VAL_W-1:0] out_read_value;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;

  trace_checker    sb;
  logic [TIME_W-1:0] tick;
  logic [VAL_W-1:0]  value_pool [4];
  int                cfg_write_count;
  int                stall_cycles;

  capped_step_trace_buffer i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_timestamp       (in_timestamp),
    .in_sample_value    (in_sample_value),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_stored_count   (out_stored_count),
    .out_points_written (out_points_written),
    .out_end_moved      (out_end_moved),
    .out_read_hit       (out_read_hit),
    .out_read_time      (out_read_time),
    .out_read_value     (out_read_value),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: switch between randomly chosen stall patterns
  initial begin
    int style;
    int span;
    out_ready = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (style)
          0:       out_ready = 1'b1;
          1:       out_ready = ($urandom_range(0, 1) == 1);
          2:       out_ready = (c % 4 == 3);
          default: out_ready = ((c % 32) >= 24);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_response({out_stored_count, out_points_written, out_end_moved,
                         out_read_hit, out_read_time, out_read_value});
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: %0d cycles without a handshake", STALL_LIMIT);
      $display("FAIL capped_step_trace_buffer");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves valid high at the next falling edge; callers lower it for a gap.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] ts,
                              input logic [VAL_W-1:0] value, input logic [IDX_W-1:0] idx);
    in_valid        = 1'b1;
    in_op           = op;
    in_timestamp    = ts;
    in_sample_value = value;
    in_read_index   = idx;
    do @(posedge clk); while (!in_ready);
    sb.predict_response(op, ts, value, idx);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    wait_drain();
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(index, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_write_count++;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [CAP_W-1:0] cap,
                           input int n_items, input int clear_pct, input int read_pct,
                           input int pool_size);
    int                burst;
    int                gap;
    int                r;
    logic [OP_W-1:0]   op;
    logic [TIME_W-1:0] ts;
    logic [VAL_W-1:0]  value;
    logic [IDX_W-1:0]  idx;
    write_register(CFG_RECORD_MODE, CFG_DATA_W'(mode));
    write_register(CFG_CAPACITY, cap);
    // a small pool of levels makes repeats, so change and move paths get hit
    for (int i = 0; i < pool_size; i++)
      value_pool[i] = $urandom;
    burst = $urandom_range(1, 30);
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < clear_pct)
        op = OP_CLEAR;
      else if (r < clear_pct + 2)
        op = OP_NOP;
      else if (r < clear_pct + 2 + read_pct)
        op = OP_READ;
      else
        op = OP_RECORD;
      tick = tick + $urandom_range(0, 400);
      ts = ($urandom_range(0, 9) == 0) ? $urandom : tick;
      r = $urandom_range(0, 19);
      if (r == 0)
        value = $urandom;
      else if (r == 1)
        value = 32'h8000_0000;
      else if (r == 2)
        value = 32'h7fff_ffff;
      else
        value = value_pool[$urandom_range(0, pool_size - 1)];
      if (sb.point_count != 0 && $urandom_range(0, 3) != 0)
        idx = IDX_W'($urandom_range(0, sb.point_count - 1));
      else
        idx = IDX_W'($urandom_range(0, DEPTH - 1));
      send_request(op, ts, value, idx);
      // hold off mid-phase until the block has answered everything
      if (n_items > 400 && i == n_items / 2)
        wait_drain();
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 30);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  endtask

  initial begin
    sb              = new();
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = OP_RECORD;
    in_timestamp    = '0;
    in_sample_value = '0;
    in_read_index   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = CFG_RECORD_MODE;
    cfg_data        = '0;
    tick            = '0;
    cfg_write_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // plain mode after reset: empty read, field extremes, no-op, clear
    send_request(OP_READ, $urandom, $urandom, 10'd0);
    send_request(OP_RECORD, 32'h0000_0000, 32'h8000_0000, 10'd0);
    send_request(OP_RECORD, 32'hffff_ffff, 32'h7fff_ffff, 10'h3ff);
    send_request(OP_READ, $urandom, $urandom, 10'd1);
    send_request(OP_READ, $urandom, $urandom, 10'h3ff);
    send_request(OP_NOP, 32'hffff_ffff, 32'hffff_ffff, 10'h3ff);
    send_request(OP_CLEAR, $urandom, $urandom, IDX_W'($urandom));
    send_request(OP_READ, $urandom, $urandom, 10'd0);

    // append on change: repeat is skipped
    write_register(CFG_RECORD_MODE, CFG_DATA_W'(MODE_CHANGE));
    send_request(OP_RECORD, 32'd100, 32'd5, 10'd0);
    send_request(OP_RECORD, 32'd101, 32'd5, 10'd0);
    send_request(OP_RECORD, 32'd102, 32'hffff_ffff, 10'd0);

    // step plot: first point, repeat append, move, corner, repeat, move
    write_register(CFG_RECORD_MODE, CFG_DATA_W'(MODE_STEP));
    send_request(OP_CLEAR, $urandom, $urandom, IDX_W'($urandom));
    send_request(OP_RECORD, 32'd200, 32'd10, 10'd0);
    send_request(OP_RECORD, 32'd201, 32'd10, 10'd0);
    send_request(OP_RECORD, 32'd202, 32'd10, 10'd0);
    send_request(OP_RECORD, 32'd203, 32'd20, 10'd0);
    send_request(OP_RECORD, 32'd204, 32'd20, 10'd0);
    send_request(OP_RECORD, 32'd205, 32'd20, 10'd0);
    send_request(OP_READ, $urandom, $urandom, 10'd3);

    // recording switched off, then capacity lowered below the count
    write_register(CFG_RECORD_MODE, CFG_DATA_W'(MODE_OFF));
    send_request(OP_RECORD, 32'd300, 32'd30, 10'd0);
    write_register(CFG_RECORD_MODE, CFG_DATA_W'(MODE_PLAIN));
    write_register(CFG_CAPACITY, 11'd2);
    send_request(OP_RECORD, 32'd301, 32'd31, 10'd0);
    send_request(OP_READ, $urandom, $urandom, 10'd0);
    write_register(CFG_SPARE2, 11'h7ff);
    write_register(CFG_SPARE3, 11'h555);

    run_phase(MODE_PLAIN, 11'd3, 120, 4, 25, 4);
    run_phase(MODE_CHANGE, 11'd17, 120, 4, 25, 3);
    run_phase(MODE_STEP, 11'd1, 100, 4, 25, 2);
    run_phase(MODE_STEP, 11'd2, 100, 4, 25, 3);
    // no clears here: fill past the depth so the store wraps
    run_phase(MODE_STEP, 11'h7ff, 700, 0, 15, 3);
    run_phase(MODE_PLAIN, 11'd1025, 200, 0, 30, 4);
    run_phase(MODE_CHANGE, 11'd0, 80, 3, 25, 2);
    run_phase(MODE_OFF, 11'd5, 50, 3, 30, 2);
    run_phase(MODE_PLAIN, 11'd4, 80, 3, 25, 4);
    run_phase(MODE_STEP, 11'd1024, 100, 3, 25, 2);

    wait_drain();
    repeat (10) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Covered %0d requests and %0d register writes: %0d read hits, %0d step changes,",
             sb.request_count, cfg_write_count, sb.hit_count, sb.step_count);
    $display("%0d end moves, store peaked at %0d points, %0d mismatches.",
             sb.move_count, sb.peak_count, sb.error_count);
    if (sb.error_count == 0)
      $display("PASS capped_step_trace_buffer");
    else
      $display("FAIL capped_step_trace_buffer");
    $finish;
  end

endmodule
